// ===== hw/rtl/emsq_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder move sequencer package
// Shared widths, codes, register layout and item types of the sequencer.
// ----------------------------------------------------------------------------
package emsq_pkg;

  // Pulse counter width; the counters wrap at this width.
  localparam int unsigned CountWidth = 16;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // Field widths.
  localparam int unsigned DutyWidth   = 12;
  localparam int unsigned AmountWidth = 16;
  localparam int unsigned TimerWidth  = 10;
  localparam int unsigned FuncWidth   = 2;

  localparam logic [DutyWidth-1:0]  DutyFull = {DutyWidth{1'b1}};
  localparam logic [TimerWidth-1:0] TimerMax = {TimerWidth{1'b1}};

  // Safety margin of a straight move in millimetres.
  localparam logic [AmountWidth-1:0] MarginMm = 16'd2;

  // Fractional bits of pulses_per_mm.
  localparam int unsigned PpmFracBits = 12;

  // Function codes of an input item.
  localparam logic [FuncWidth-1:0] FuncSample = 2'd0;
  localparam logic [FuncWidth-1:0] FuncLinear = 2'd1;
  localparam logic [FuncWidth-1:0] FuncRotate = 2'd2;

  // Configuration register indexes (byte address is four times the index).
  localparam int unsigned PaddrWidth = 5;
  localparam logic [2:0] RegDrivePower      = 3'd0;
  localparam logic [2:0] RegRightBrakeLevel = 3'd1;
  localparam logic [2:0] RegPulsesPerMm     = 3'd2;
  localparam logic [2:0] RegRotateInner     = 3'd3;
  localparam logic [2:0] RegRotateOuter     = 3'd4;
  localparam logic [2:0] RegBrakeTicks      = 3'd5;

  // Motion phase, also reported on the result.
  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhLinear = 2'd1,
    PhRotate = 2'd2,
    PhBrake  = 2'd3
  } phase_e;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [DutyWidth-1:0]  drive_power;
    logic [DutyWidth-1:0]  right_brake_level;
    logic [15:0]           pulses_per_mm;
    logic [7:0]            rotate_inner_per_degree;
    logic [7:0]            rotate_outer_per_degree;
    logic [TimerWidth-1:0] brake_ticks;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [FuncWidth-1:0]          func;
    logic                          left_pulse;
    logic                          right_pulse;
    logic                          ms_tick;
    logic signed [AmountWidth-1:0] amount;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [DutyWidth-1:0]  left_fwd_duty;
    logic [DutyWidth-1:0]  left_rev_duty;
    logic [DutyWidth-1:0]  right_fwd_duty;
    logic [DutyWidth-1:0]  right_rev_duty;
    logic [CountWidth-1:0] left_count;
    logic [CountWidth-1:0] right_count;
    phase_e                phase;
  } out_item_t;

  // Saturate a wide product to the counter range.
  function automatic logic [CountWidth-1:0] sat_count(input logic [31:0] v);
    logic [CountWidth-1:0] r;
    if (v > 32'(CountMax)) begin
      r = CountMax;
    end else begin
      r = v[CountWidth-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/emsq_in_if.sv =====
// ----------------------------------------------------------------------------
// Encoder move sequencer input channel
// Valid/ready channel carrying one sample or command item.
// ----------------------------------------------------------------------------
interface emsq_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [emsq_pkg::FuncWidth-1:0]         func;
  logic                                   left_pulse;
  logic                                   right_pulse;
  logic                                   ms_tick;
  logic signed [emsq_pkg::AmountWidth-1:0] amount;

  modport source (output valid, func, left_pulse, right_pulse, ms_tick, amount,
                  input ready);
  modport sink (input valid, func, left_pulse, right_pulse, ms_tick, amount,
                output ready);
endinterface

// ===== hw/rtl/emsq_out_if.sv =====
// ----------------------------------------------------------------------------
// Encoder move sequencer result channel
// Valid/ready channel carrying motor duties, counters and phase.
// ----------------------------------------------------------------------------
interface emsq_out_if;
  logic                                valid;
  logic                                ready;
  logic [emsq_pkg::DutyWidth-1:0]      left_fwd_duty;
  logic [emsq_pkg::DutyWidth-1:0]      left_rev_duty;
  logic [emsq_pkg::DutyWidth-1:0]      right_fwd_duty;
  logic [emsq_pkg::DutyWidth-1:0]      right_rev_duty;
  logic [emsq_pkg::CountWidth-1:0]     left_count;
  logic [emsq_pkg::CountWidth-1:0]     right_count;
  logic [1:0]                          phase;

  modport source (output valid, left_fwd_duty, left_rev_duty, right_fwd_duty,
                  right_rev_duty, left_count, right_count, phase,
                  input ready);
  modport sink (input valid, left_fwd_duty, left_rev_duty, right_fwd_duty,
                right_rev_duty, left_count, right_count, phase,
                output ready);
endinterface

// ===== hw/rtl/emsq_cfg.sv =====
// ----------------------------------------------------------------------------
// Encoder move sequencer configuration registers
// APB-style register file holding the six sequencer settings.
// ----------------------------------------------------------------------------
module emsq_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [emsq_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output emsq_pkg::cfg_t                  cfg_o
);

  emsq_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_idx;

  // Register index from the word address; the access phase completes at once.
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_power             <= 12'd2048;
      cfg_q.right_brake_level       <= 12'd4095;
      cfg_q.pulses_per_mm           <= 16'd372;
      cfg_q.rotate_inner_per_degree <= 8'd1;
      cfg_q.rotate_outer_per_degree <= 8'd1;
      cfg_q.brake_ticks             <= 10'd100;
    end else if (wr_en) begin
      case (reg_idx)
        emsq_pkg::RegDrivePower:      cfg_q.drive_power <= pwdata[11:0];
        emsq_pkg::RegRightBrakeLevel: cfg_q.right_brake_level <= pwdata[11:0];
        emsq_pkg::RegPulsesPerMm:     cfg_q.pulses_per_mm <= pwdata[15:0];
        emsq_pkg::RegRotateInner:     cfg_q.rotate_inner_per_degree <= pwdata[7:0];
        emsq_pkg::RegRotateOuter:     cfg_q.rotate_outer_per_degree <= pwdata[7:0];
        emsq_pkg::RegBrakeTicks:      cfg_q.brake_ticks <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    prdata = 32'd0;
    case (reg_idx)
      emsq_pkg::RegDrivePower:      prdata = 32'(cfg_q.drive_power);
      emsq_pkg::RegRightBrakeLevel: prdata = 32'(cfg_q.right_brake_level);
      emsq_pkg::RegPulsesPerMm:     prdata = 32'(cfg_q.pulses_per_mm);
      emsq_pkg::RegRotateInner:     prdata = 32'(cfg_q.rotate_inner_per_degree);
      emsq_pkg::RegRotateOuter:     prdata = 32'(cfg_q.rotate_outer_per_degree);
      emsq_pkg::RegBrakeTicks:      prdata = 32'(cfg_q.brake_ticks);
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/emsq_goal.sv =====
// ----------------------------------------------------------------------------
// Encoder move sequencer target calculation
// Pulse targets of both sides for a straight move or a rotation.
// ----------------------------------------------------------------------------
module emsq_goal (
  input  logic [emsq_pkg::AmountWidth-1:0] mag_i,
  input  logic                             neg_i,
  input  logic                             linear_i,
  input  emsq_pkg::cfg_t                   cfg_i,
  output logic [emsq_pkg::CountWidth-1:0]  left_goal_o,
  output logic [emsq_pkg::CountWidth-1:0]  right_goal_o
);

  logic [emsq_pkg::AmountWidth-1:0] lin_mm;
  logic [31:0]                      lin_prod;
  logic [19:0]                      lin_pulses;
  logic [emsq_pkg::CountWidth-1:0]  lin_goal;
  logic [23:0]                      in_prod;
  logic [23:0]                      out_prod;
  logic [emsq_pkg::CountWidth-1:0]  in_goal;
  logic [emsq_pkg::CountWidth-1:0]  out_goal;

  // Straight move: distance less the margin, scaled by the Q4.12 pulse rate.
  assign lin_mm     = mag_i - emsq_pkg::MarginMm;
  assign lin_prod   = 32'(lin_mm) * 32'(cfg_i.pulses_per_mm);
  assign lin_pulses = lin_prod[31:emsq_pkg::PpmFracBits];
  assign lin_goal   = (mag_i > emsq_pkg::MarginMm) ?
                      emsq_pkg::sat_count(32'(lin_pulses)) : '0;

  // Rotation: degrees times the inner and outer pulse rates.
  assign in_prod  = 24'(cfg_i.rotate_inner_per_degree) * 24'(mag_i);
  assign out_prod = 24'(cfg_i.rotate_outer_per_degree) * 24'(mag_i);
  assign in_goal  = emsq_pkg::sat_count(32'(in_prod));
  assign out_goal = emsq_pkg::sat_count(32'(out_prod));

  // A negative rotation swaps the inner and outer sides.
  always_comb begin
    if (linear_i) begin
      left_goal_o  = lin_goal;
      right_goal_o = lin_goal;
    end else if (neg_i) begin
      left_goal_o  = in_goal;
      right_goal_o = out_goal;
    end else begin
      left_goal_o  = out_goal;
      right_goal_o = in_goal;
    end
  end

endmodule

// ===== hw/rtl/emsq_core.sv =====
// ----------------------------------------------------------------------------
// Encoder move sequencer core
// Motion state, pulse counters and result forming for one item per cycle while fire_i is high.
// ----------------------------------------------------------------------------
module emsq_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  emsq_pkg::in_item_t  item_i,
  input  emsq_pkg::cfg_t      cfg_i,
  output emsq_pkg::out_item_t result_o
);

  logic [emsq_pkg::CountWidth-1:0] left_pulses_q, left_pulses_d;
  logic [emsq_pkg::CountWidth-1:0] right_pulses_q, right_pulses_d;
  logic [emsq_pkg::CountWidth-1:0] left_goal_q, left_goal_d;
  logic [emsq_pkg::CountWidth-1:0] right_goal_q, right_goal_d;
  logic [emsq_pkg::TimerWidth-1:0] brake_timer_q, brake_timer_d;
  emsq_pkg::phase_e                phase_q, phase_d;
  logic                            left_done_q, left_done_d;
  logic                            right_done_q, right_done_d;
  logic                            reverse_q, reverse_d;

  logic [emsq_pkg::AmountWidth-1:0] amt_raw;
  logic [emsq_pkg::AmountWidth-1:0] mag;
  logic                             neg;
  logic                             is_cmd;
  logic                             start;
  logic [emsq_pkg::CountWidth-1:0]  new_left_goal;
  logic [emsq_pkg::CountWidth-1:0]  new_right_goal;

  // Magnitude and sign of the commanded amount.
  assign amt_raw = item_i.amount;
  assign neg     = amt_raw[emsq_pkg::AmountWidth-1];
  assign mag     = neg ? (~amt_raw + 16'd1) : amt_raw;
  assign is_cmd  = (item_i.func == emsq_pkg::FuncLinear) ||
                   (item_i.func == emsq_pkg::FuncRotate);
  assign start   = fire_i && is_cmd && (phase_q == emsq_pkg::PhIdle) && (mag != '0);

  emsq_goal u_goal (
    .mag_i        (mag),
    .neg_i        (neg),
    .linear_i     (item_i.func == emsq_pkg::FuncLinear),
    .cfg_i        (cfg_i),
    .left_goal_o  (new_left_goal),
    .right_goal_o (new_right_goal)
  );

  // Next state for the item being processed.
  always_comb begin
    left_pulses_d  = left_pulses_q;
    right_pulses_d = right_pulses_q;
    left_goal_d    = left_goal_q;
    right_goal_d   = right_goal_q;
    brake_timer_d  = brake_timer_q;
    phase_d        = phase_q;
    left_done_d    = left_done_q;
    right_done_d   = right_done_q;
    reverse_d      = reverse_q;
    if (fire_i && (item_i.func == emsq_pkg::FuncSample)) begin
      left_pulses_d  = left_pulses_q + emsq_pkg::CountWidth'(item_i.left_pulse);
      right_pulses_d = right_pulses_q + emsq_pkg::CountWidth'(item_i.right_pulse);
      case (phase_q)
        emsq_pkg::PhBrake: begin
          if (item_i.ms_tick && (brake_timer_q != emsq_pkg::TimerMax)) begin
            brake_timer_d = brake_timer_q + 10'd1;
          end
          if (brake_timer_d >= cfg_i.brake_ticks) begin
            phase_d = emsq_pkg::PhIdle;
          end
        end
        emsq_pkg::PhLinear: begin
          if (left_pulses_d >= left_goal_q) begin
            left_done_d = 1'b1;
          end
          if (right_pulses_d >= right_goal_q) begin
            right_done_d = 1'b1;
          end
          if (left_done_d && right_done_d) begin
            phase_d       = emsq_pkg::PhBrake;
            brake_timer_d = '0;
          end
        end
        emsq_pkg::PhRotate: begin
          if ((left_pulses_d >= left_goal_q) || (right_pulses_d >= right_goal_q)) begin
            phase_d       = emsq_pkg::PhBrake;
            brake_timer_d = '0;
          end
        end
        default: ;
      endcase
    end else if (start) begin
      left_pulses_d  = '0;
      right_pulses_d = '0;
      left_done_d    = 1'b0;
      right_done_d   = 1'b0;
      brake_timer_d  = '0;
      reverse_d      = neg;
      left_goal_d    = new_left_goal;
      right_goal_d   = new_right_goal;
      phase_d        = (item_i.func == emsq_pkg::FuncLinear) ?
                       emsq_pkg::PhLinear : emsq_pkg::PhRotate;
    end
  end

  // Motion state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_pulses_q  <= '0;
      right_pulses_q <= '0;
      left_goal_q    <= '0;
      right_goal_q   <= '0;
      brake_timer_q  <= '0;
      phase_q        <= emsq_pkg::PhIdle;
      left_done_q    <= 1'b0;
      right_done_q   <= 1'b0;
      reverse_q      <= 1'b0;
    end else begin
      left_pulses_q  <= left_pulses_d;
      right_pulses_q <= right_pulses_d;
      left_goal_q    <= left_goal_d;
      right_goal_q   <= right_goal_d;
      brake_timer_q  <= brake_timer_d;
      phase_q        <= phase_d;
      left_done_q    <= left_done_d;
      right_done_q   <= right_done_d;
      reverse_q      <= reverse_d;
    end
  end

  // Result from the updated state.
  always_comb begin
    result_o.left_fwd_duty  = '0;
    result_o.left_rev_duty  = '0;
    result_o.right_fwd_duty = '0;
    result_o.right_rev_duty = '0;
    result_o.left_count     = left_pulses_d;
    result_o.right_count    = right_pulses_d;
    result_o.phase          = phase_d;
    case (phase_d)
      emsq_pkg::PhLinear: begin
        if (left_done_d) begin
          result_o.left_fwd_duty = emsq_pkg::DutyFull;
          result_o.left_rev_duty = emsq_pkg::DutyFull;
        end else if (reverse_d) begin
          result_o.left_rev_duty = cfg_i.drive_power;
        end else begin
          result_o.left_fwd_duty = cfg_i.drive_power;
        end
        if (right_done_d) begin
          result_o.right_fwd_duty = emsq_pkg::DutyFull;
          result_o.right_rev_duty = emsq_pkg::DutyFull;
        end else if (reverse_d) begin
          result_o.right_rev_duty = cfg_i.drive_power;
        end else begin
          result_o.right_fwd_duty = cfg_i.drive_power;
        end
      end
      emsq_pkg::PhRotate: begin
        // Sides run in opposite directions.
        if (reverse_d) begin
          result_o.left_rev_duty  = cfg_i.drive_power;
          result_o.right_fwd_duty = cfg_i.drive_power;
        end else begin
          result_o.left_fwd_duty  = cfg_i.drive_power;
          result_o.right_rev_duty = cfg_i.drive_power;
        end
      end
      emsq_pkg::PhBrake: begin
        result_o.left_fwd_duty  = emsq_pkg::DutyFull;
        result_o.left_rev_duty  = emsq_pkg::DutyFull;
        result_o.right_fwd_duty = cfg_i.right_brake_level;
        result_o.right_rev_duty = cfg_i.right_brake_level;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/encoder_move_sequencer.sv =====
// ----------------------------------------------------------------------------
// Encoder move sequencer
// Counts front encoder pulses, drives both motor sides and brakes on target.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Transaction
//  in_i      sink       valid / ready    one sample or move command
//  out_o     source     valid / ready    duties, counters and phase
//  apb       slave      psel / penable   one register write or read
//
// One transaction is accepted per cycle while neither stage is stalled; its
// result passes the input register and then the result register, which
// lie around the combinational update logic.
// A stalled result register holds its transaction while the input register
// still accepts one more; both stages then hold until the sink takes one.
// Reset clears the motion state and loads the documented register defaults.
// ----------------------------------------------------------------------------
module encoder_move_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  emsq_in_if.sink                         in_i,
  emsq_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [emsq_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  emsq_pkg::cfg_t      cfg;
  emsq_pkg::in_item_t  in_item_q;
  emsq_pkg::out_item_t result;
  emsq_pkg::out_item_t out_item_q;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                out_adv;
  logic                fire;

  emsq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage flow: the result register frees when empty or being taken.
  assign out_adv    = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && out_adv;
  assign in_i.ready = !in_valid_q || fire;

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q.func        <= in_i.func;
      in_item_q.left_pulse  <= in_i.left_pulse;
      in_item_q.right_pulse <= in_i.right_pulse;
      in_item_q.ms_tick     <= in_i.ms_tick;
      in_item_q.amount      <= in_i.amount;
    end
  end

  emsq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.left_fwd_duty  = out_item_q.left_fwd_duty;
  assign out_o.left_rev_duty  = out_item_q.left_rev_duty;
  assign out_o.right_fwd_duty = out_item_q.right_fwd_duty;
  assign out_o.right_rev_duty = out_item_q.right_rev_duty;
  assign out_o.left_count     = out_item_q.left_count;
  assign out_o.right_count    = out_item_q.right_count;
  assign out_o.phase          = out_item_q.phase;

  // A processed transaction always lands in the result register.
  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed transaction did not reach the result register");

  // A blocked input stage keeps its transaction.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_adv) |=> in_valid_q)
    else $error("input stage dropped a transaction while blocked");

  // An idle result releases every motor pin.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.phase == emsq_pkg::PhIdle)) |->
    ((out_item_q.left_fwd_duty == '0) && (out_item_q.left_rev_duty == '0) &&
     (out_item_q.right_fwd_duty == '0) && (out_item_q.right_rev_duty == '0)))
    else $error("idle result drives a motor pin");

  // A braking result holds the left side at full duty on both pins.
  a_brake_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.phase == emsq_pkg::PhBrake)) |->
    ((out_item_q.left_fwd_duty == emsq_pkg::DutyFull) &&
     (out_item_q.left_rev_duty == emsq_pkg::DutyFull)))
    else $error("braking result without full left brake");

endmodule
